// File: design/b32m_pkg.sv
// Shared types, constants and functions of the bech32m address encoder.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package b32m_pkg;

    localparam int MAX_PREFIX_CHARS = 8;
    localparam int CFG_ADDR_W       = 5;
    localparam int CFG_DATA_W       = 64;
    localparam int CKS_GROUPS       = 6;

    localparam logic [1:0] REG_PREFIX_CHARS    = 2'd0;
    localparam logic [1:0] REG_PREFIX_LENGTH   = 2'd1;
    localparam logic [1:0] REG_WITNESS_VERSION = 2'd2;

    localparam logic [55:0] PREFIX_CHARS_RST    = 56'h6362;
    localparam logic [3:0]  PREFIX_LENGTH_RST   = 4'd2;
    localparam logic [4:0]  WITNESS_VERSION_RST = 5'd1;

    localparam logic [29:0] B32M_CONST = 30'h2bc830a3;
    localparam logic [6:0]  SEP_CHAR   = 7'h31;
    localparam logic [29:0] GEN [5] = '{
        30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
    };
    localparam logic [8*32-1:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    typedef enum logic [2:0] {
        SYM_PRE_HI = 3'd0,
        SYM_PRE_LO = 3'd1,
        SYM_ZERO   = 3'd2,
        SYM_VER    = 3'd3,
        SYM_DATA   = 3'd4,
        SYM_PAD    = 3'd5,
        SYM_CKS    = 3'd6
    } t_sym_src;

    typedef enum logic [1:0] {
        CHAR_PREFIX = 2'd0,
        CHAR_SEP    = 2'd1,
        CHAR_SYM    = 2'd2
    } t_char_src;

    typedef struct packed {
        logic [55:0] prefix_chars;
        logic [3:0]  prefix_length;
        logic [4:0]  witness_version;
    } t_cfg;

    typedef struct packed {
        logic      load;
        logic      new_run;
        logic      init_chk;
        logic      fold_en;
        logic      xor_const;
        logic      shift_cks;
        logic      data_step;
        logic      emit_en;
        logic      emit_last;
        t_sym_src  sym_src;
        t_char_src char_src;
        logic [2:0] idx;
    } t_cmd;

    typedef struct packed {
        logic       can_emit;
        logic [3:0] pre_len;
        logic       data_more;
        logic       pad_after;
        logic       is_last;
    } t_stat;

    function automatic logic [29:0] fold(input logic [29:0] chk, input logic [4:0] sym);
        logic [29:0] c;
        logic [4:0]  top;
        top = chk[29:25];
        c   = {chk[24:0], 5'b0} ^ {25'b0, sym};
        for (int i = 0; i < 5; i++) begin
            if (top[i]) begin
                c = c ^ GEN[i];
            end
        end
        return c;
    endfunction

    function automatic logic [6:0] alpha_char(input logic [4:0] sym);
        return ALPHABET[8 * (5'd31 - sym) +: 7];
    endfunction

    function automatic logic [6:0] prefix_char(input logic [55:0] pc, input logic [2:0] idx);
        logic [6:0] ch;
        ch = 7'd0;
        if (idx != 3'd7) begin
            ch = pc[8 * idx +: 7];
        end
        return ch;
    endfunction

endpackage

// File: design/b32m_in_if.sv
// Input channel of the bech32m encoder: one witness-program byte per item.
// Depends on nothing.
`timescale 1ns / 1ps

interface b32m_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] program_byte;
    logic       is_last_byte;

    modport source (output valid, output program_byte, output is_last_byte, input ready);
    modport sink   (input valid, input program_byte, input is_last_byte, output ready);
endinterface

// File: design/b32m_out_if.sv
// Output channel of the bech32m encoder: one address character per item.
// Depends on nothing.
`timescale 1ns / 1ps

interface b32m_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] address_char;
    logic       is_last_char;

    modport source (output valid, output address_char, output is_last_char, input ready);
    modport sink   (input valid, input address_char, input is_last_char, output ready);
endinterface

// File: design/b32m_regs.sv
// APB configuration registers: prefix characters, prefix length, witness version.
// Depends on b32m_pkg.
`timescale 1ns / 1ps

module b32m_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [b32m_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [b32m_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [b32m_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output b32m_pkg::t_cfg                      o_cfg
);

    b32m_pkg::t_cfg r_cfg;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel & penable & pwrite & pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prefix_chars    <= b32m_pkg::PREFIX_CHARS_RST;
            r_cfg.prefix_length   <= b32m_pkg::PREFIX_LENGTH_RST;
            r_cfg.witness_version <= b32m_pkg::WITNESS_VERSION_RST;
        end else if (wr_en) begin
            case (reg_idx)
                b32m_pkg::REG_PREFIX_CHARS:    r_cfg.prefix_chars    <= pwdata[55:0];
                b32m_pkg::REG_PREFIX_LENGTH:   r_cfg.prefix_length   <= pwdata[3:0];
                b32m_pkg::REG_WITNESS_VERSION: r_cfg.witness_version <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            b32m_pkg::REG_PREFIX_CHARS:    prdata = {8'b0, r_cfg.prefix_chars};
            b32m_pkg::REG_PREFIX_LENGTH:   prdata = {60'b0, r_cfg.prefix_length};
            b32m_pkg::REG_WITNESS_VERSION: prdata = {59'b0, r_cfg.witness_version};
            default:                       prdata = '0;
        endcase
    end

endmodule

// File: design/b32m_datapath.sv
// Datapath: polymod register and fold unit, 5-bit regrouping, character
// output register. Driven by b32m_ctrl commands; depends on b32m_pkg.
`timescale 1ns / 1ps

module b32m_datapath #(
    parameter int MAX_PREFIX_CHARS = b32m_pkg::MAX_PREFIX_CHARS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  b32m_pkg::t_cfg    i_cfg,
    input  b32m_pkg::t_cmd    i_cmd,
    input  logic [7:0]        i_program_byte,
    input  logic              i_is_last_byte,
    input  logic              i_out_ready,
    output b32m_pkg::t_stat   o_stat,
    output logic              o_out_valid,
    output logic [6:0]        o_address_char,
    output logic              o_is_last_char
);

    logic [29:0] r_chk, n_chk;
    logic [11:0] r_acc;
    logic [3:0]  r_bits;
    logic        r_last;
    logic        r_out_valid;
    logic [6:0]  r_char;
    logic        r_out_last;

    logic [6:0]  pch;
    logic [4:0]  sym;
    logic [6:0]  ch;
    logic [3:0]  left_mask;
    logic [3:0]  left;
    logic [3:0]  data_sh;
    logic [4:0]  data_sym;
    logic [4:0]  pad_sym;
    logic [3:0]  eff_len;

    assign pch       = b32m_pkg::prefix_char(i_cfg.prefix_chars, i_cmd.idx);
    assign left_mask = 4'((5'd1 << r_bits[2:0]) - 5'd1);
    assign left      = r_acc[3:0] & left_mask;
    assign data_sh   = r_bits - 4'd5;
    assign data_sym  = 5'(r_acc >> data_sh);
    assign pad_sym   = 5'({1'b0, left} << (3'd5 - r_bits[2:0]));

    always_comb begin
        if (i_cfg.prefix_length == 4'd0) begin
            eff_len = 4'd1;
        end else if (i_cfg.prefix_length > 4'(MAX_PREFIX_CHARS)) begin
            eff_len = 4'(MAX_PREFIX_CHARS);
        end else begin
            eff_len = i_cfg.prefix_length;
        end
    end

    always_comb begin
        case (i_cmd.sym_src)
            b32m_pkg::SYM_PRE_HI: sym = {3'b0, pch[6:5]};
            b32m_pkg::SYM_PRE_LO: sym = pch[4:0];
            b32m_pkg::SYM_ZERO:   sym = 5'd0;
            b32m_pkg::SYM_VER:    sym = i_cfg.witness_version;
            b32m_pkg::SYM_DATA:   sym = data_sym;
            b32m_pkg::SYM_PAD:    sym = pad_sym;
            b32m_pkg::SYM_CKS:    sym = r_chk[29:25];
            default:              sym = 5'd0;
        endcase
    end

    always_comb begin
        case (i_cmd.char_src)
            b32m_pkg::CHAR_PREFIX: ch = pch;
            b32m_pkg::CHAR_SEP:    ch = b32m_pkg::SEP_CHAR;
            b32m_pkg::CHAR_SYM:    ch = b32m_pkg::alpha_char(sym);
            default:               ch = 7'd0;
        endcase
    end

    always_comb begin
        n_chk = r_chk;
        if (i_cmd.init_chk) begin
            n_chk = 30'd1;
        end else if (i_cmd.fold_en) begin
            n_chk = b32m_pkg::fold(r_chk, sym) ^ (i_cmd.xor_const ? b32m_pkg::B32M_CONST : 30'd0);
        end else if (i_cmd.shift_cks) begin
            n_chk = {r_chk[24:0], 5'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk <= n_chk;
        if (i_cmd.load) begin
            r_acc  <= {(i_cmd.new_run ? 4'd0 : left), i_program_byte};
            r_bits <= (i_cmd.new_run ? 4'd0 : r_bits) + 4'd8;
            r_last <= i_is_last_byte;
        end else if (i_cmd.data_step) begin
            r_bits <= data_sh;
        end
        if (i_cmd.emit_en) begin
            r_char     <= ch;
            r_out_last <= i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_en) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.can_emit  = !r_out_valid | i_out_ready;
    assign o_stat.pre_len   = eff_len;
    assign o_stat.data_more = r_bits >= 4'd10;
    assign o_stat.pad_after = r_bits != 4'd5;
    assign o_stat.is_last   = r_last;

    assign o_out_valid    = r_out_valid;
    assign o_address_char = r_char;
    assign o_is_last_char = r_out_last;

endmodule

// File: design/b32m_ctrl.sv
// Controller state machine: sequences prefix, separator, version, data,
// padding and checksum steps. Depends on b32m_pkg.
`timescale 1ns / 1ps

module b32m_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  b32m_pkg::t_stat i_stat,
    output b32m_pkg::t_cmd  o_cmd
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_PRE_HI = 9'b000000010,
        ST_SEP    = 9'b000000100,
        ST_PRE_LO = 9'b000001000,
        ST_VER    = 9'b000010000,
        ST_DATA   = 9'b000100000,
        ST_PAD    = 9'b001000000,
        ST_ZERO   = 9'b010000000,
        ST_CKS    = 9'b100000000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_idx, n_idx;
    logic       r_run, n_run;
    logic       pre_end;
    logic       grp_end;

    assign o_in_ready = (r_state == ST_IDLE);
    assign pre_end    = ({1'b0, r_idx} + 4'd1) == i_stat.pre_len;
    assign grp_end    = r_idx == 3'(b32m_pkg::CKS_GROUPS - 1);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_run   = r_run;
        o_cmd   = '0;
        o_cmd.sym_src  = b32m_pkg::SYM_ZERO;
        o_cmd.char_src = b32m_pkg::CHAR_SYM;
        o_cmd.idx      = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.new_run  = !r_run;
                    o_cmd.init_chk = !r_run;
                    n_idx          = 3'd0;
                    n_run          = 1'b1;
                    n_state        = r_run ? ST_DATA : ST_PRE_HI;
                end
            end
            ST_PRE_HI: begin
                o_cmd.sym_src  = b32m_pkg::SYM_PRE_HI;
                o_cmd.char_src = b32m_pkg::CHAR_PREFIX;
                if (i_stat.can_emit) begin
                    o_cmd.emit_en = 1'b1;
                    o_cmd.fold_en = 1'b1;
                    if (pre_end) begin
                        n_idx   = 3'd0;
                        n_state = ST_SEP;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            ST_SEP: begin
                o_cmd.char_src = b32m_pkg::CHAR_SEP;
                if (i_stat.can_emit) begin
                    o_cmd.emit_en = 1'b1;
                    o_cmd.fold_en = 1'b1;
                    n_state       = ST_PRE_LO;
                end
            end
            ST_PRE_LO: begin
                o_cmd.sym_src = b32m_pkg::SYM_PRE_LO;
                o_cmd.fold_en = 1'b1;
                if (pre_end) begin
                    n_idx   = 3'd0;
                    n_state = ST_VER;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            ST_VER: begin
                o_cmd.sym_src = b32m_pkg::SYM_VER;
                if (i_stat.can_emit) begin
                    o_cmd.emit_en = 1'b1;
                    o_cmd.fold_en = 1'b1;
                    n_state       = ST_DATA;
                end
            end
            ST_DATA: begin
                o_cmd.sym_src = b32m_pkg::SYM_DATA;
                if (i_stat.can_emit) begin
                    o_cmd.emit_en   = 1'b1;
                    o_cmd.fold_en   = 1'b1;
                    o_cmd.data_step = 1'b1;
                    if (!i_stat.data_more) begin
                        if (!i_stat.is_last) begin
                            n_state = ST_IDLE;
                        end else if (i_stat.pad_after) begin
                            n_state = ST_PAD;
                        end else begin
                            n_idx   = 3'd0;
                            n_state = ST_ZERO;
                        end
                    end
                end
            end
            ST_PAD: begin
                o_cmd.sym_src = b32m_pkg::SYM_PAD;
                if (i_stat.can_emit) begin
                    o_cmd.emit_en = 1'b1;
                    o_cmd.fold_en = 1'b1;
                    n_idx         = 3'd0;
                    n_state       = ST_ZERO;
                end
            end
            ST_ZERO: begin
                o_cmd.fold_en   = 1'b1;
                o_cmd.xor_const = grp_end;
                if (grp_end) begin
                    n_idx   = 3'd0;
                    n_state = ST_CKS;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            ST_CKS: begin
                o_cmd.sym_src = b32m_pkg::SYM_CKS;
                if (i_stat.can_emit) begin
                    o_cmd.emit_en   = 1'b1;
                    o_cmd.emit_last = grp_end;
                    o_cmd.shift_cks = 1'b1;
                    if (grp_end) begin
                        n_idx   = 3'd0;
                        n_run   = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= 3'd0;
            r_run   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_run   <= n_run;
        end
    end

endmodule

// File: design/bech32m_address_encoder.sv
// Top level of the bech32m address encoder: APB registers, controller, datapath.
// Depends on b32m_pkg, b32m_in_if, b32m_out_if, b32m_regs, b32m_ctrl, b32m_datapath.
//
//  channel   direction  handshake        payload
//  i_in      in         valid / ready    program_byte[7:0], is_last_byte
//  o_out     out        valid / ready    address_char[6:0], is_last_char
//  apb       in         psel / penable   paddr[4:0], pwdata[63:0], prdata[63:0]
//
// Each emitted character or folded symbol is one step; each byte is taken in idle.
// A first byte adds the prefix, separator, prefix-fold and version steps; a last
// byte adds a pad step where needed, six zero folds and six checksum characters.
// The fold unit in the datapath takes one 5-bit symbol per cycle while not stalled.
// Reset is synchronous, active low; it ends any run in progress.
// A stalled output holds the controller in any step that emits a character.
`timescale 1ns / 1ps

module bech32m_address_encoder #(
    parameter int MAX_PREFIX_CHARS = b32m_pkg::MAX_PREFIX_CHARS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    b32m_in_if.sink                          i_in,
    b32m_out_if.source                       o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [b32m_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [b32m_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [b32m_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);

    b32m_pkg::t_cfg  cfg;
    b32m_pkg::t_cmd  cmd;
    b32m_pkg::t_stat stat;
    logic            in_ready;

    assign i_in.ready = in_ready;

    b32m_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    b32m_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    b32m_datapath #(
        .MAX_PREFIX_CHARS (MAX_PREFIX_CHARS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .i_program_byte (i_in.program_byte),
        .i_is_last_byte (i_in.is_last_byte),
        .i_out_ready    (o_out.ready),
        .o_stat         (stat),
        .o_out_valid    (o_out.valid),
        .o_address_char (o_out.address_char),
        .o_is_last_char (o_out.is_last_char)
    );

endmodule
